// ===== design/sipr_pkg.sv =====
// Shared types and constants for the soft I/Q phase rotation block.
package sipr_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);
  localparam int unsigned QueueCntW = $clog2(QueueDepth + 1);
  localparam logic [ByteW-1:0] OutMask = 8'h7F;
  localparam logic [ByteW-1:0] InvMask = 8'hFF;

  typedef enum logic [1:0] {
    ROT_NONE  = 2'd0,
    ROT_INV_Q = 2'd1,
    ROT_INV_B = 2'd2,
    ROT_INV_I = 2'd3
  } rot_e;

  typedef struct packed {
    logic             last;
    logic [ByteW-1:0] q;
    logic [ByteW-1:0] i;
  } pair_t;

  typedef struct packed {
    logic  v0;
    logic  v1;
    pair_t d0;
    pair_t d1;
  } push_t;

  localparam int unsigned CfgPhaseSel = 0;

endpackage

// ===== design/sipr_rotate.sv =====
// Rotation, optional I/Q swap and output mask for one soft pair.
module sipr_rotate (
  input  logic [2:0]              sel_i,
  input  logic [sipr_pkg::ByteW-1:0] soft_i_i,
  input  logic [sipr_pkg::ByteW-1:0] soft_q_i,
  output logic [sipr_pkg::ByteW-1:0] rot_i_o,
  output logic [sipr_pkg::ByteW-1:0] rot_q_o
);

  logic [sipr_pkg::ByteW-1:0] a;
  logic [sipr_pkg::ByteW-1:0] b;
  sipr_pkg::rot_e             rot;

  assign rot = sipr_pkg::rot_e'(sel_i[1:0]);

  always_comb begin
    a = soft_i_i;
    b = soft_q_i;
    case (rot)
      sipr_pkg::ROT_NONE: begin
      end
      sipr_pkg::ROT_INV_Q: begin
        b = soft_q_i ^ sipr_pkg::InvMask;
      end
      sipr_pkg::ROT_INV_B: begin
        a = soft_i_i ^ sipr_pkg::InvMask;
        b = soft_q_i ^ sipr_pkg::InvMask;
      end
      sipr_pkg::ROT_INV_I: begin
        a = soft_i_i ^ sipr_pkg::InvMask;
      end
      default: begin
      end
    endcase
  end

  assign rot_i_o = (sel_i[2] ? b : a) ^ sipr_pkg::OutMask;
  assign rot_q_o = (sel_i[2] ? a : b) ^ sipr_pkg::OutMask;

endmodule

// ===== design/sipr_delay_fix.sv =====
// Offset-QPSK delay correction: holds one I byte and forms up to two result items.
module sipr_delay_fix (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       delay_mode_i,
  input  logic [sipr_pkg::ByteW-1:0] rot_i_i,
  input  logic [sipr_pkg::ByteW-1:0] rot_q_i,
  input  logic                       last_i,
  output sipr_pkg::push_t            push_o
);

  logic [sipr_pkg::ByteW-1:0] held_i_q, held_i_d;
  logic                       held_vld_q, held_vld_d;
  sipr_pkg::pair_t            tail;

  assign tail = '{last: 1'b1, q: '0, i: rot_i_i};

  always_comb begin
    push_o     = '0;
    held_i_d   = held_i_q;
    held_vld_d = held_vld_q;
    if (!delay_mode_i) begin
      push_o.v0  = en_i;
      push_o.d0  = '{last: last_i, q: rot_q_i, i: rot_i_i};
      held_vld_d = 1'b0;
    end else begin
      if (held_vld_q) begin
        push_o.v0 = en_i;
        push_o.d0 = '{last: 1'b0, q: rot_q_i, i: held_i_q};
        push_o.v1 = en_i && last_i;
        push_o.d1 = tail;
      end else begin
        push_o.v0 = en_i && last_i;
        push_o.d0 = tail;
      end
      held_vld_d = !last_i;
      held_i_d   = rot_i_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_vld_q <= 1'b0;
    end else if (en_i) begin
      held_vld_q <= held_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      held_i_q <= held_i_d;
    end
  end

endmodule

// ===== design/sipr_out_fifo.sv =====
// Small result queue that takes up to two items per cycle and gives one.
module sipr_out_fifo (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sipr_pkg::push_t                 push_i,
  output logic                            room2_o,
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  output sipr_pkg::pair_t                 m_pair_o
);

  sipr_pkg::pair_t                  mem_q [sipr_pkg::QueueDepth];
  logic [sipr_pkg::QueuePtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [sipr_pkg::QueueCntW-1:0]   cnt_q, cnt_d;
  logic [sipr_pkg::QueuePtrW-1:0]   wr_nxt;
  logic                             pop;
  logic [1:0]                       n_push;

  assign pop        = m_tvalid_o && m_tready_i;
  assign m_tvalid_o = (cnt_q != '0);
  assign m_pair_o   = mem_q[rd_q];
  assign room2_o    = (cnt_q <= sipr_pkg::QueueCntW'(sipr_pkg::QueueDepth - 2));
  assign wr_nxt     = wr_q + sipr_pkg::QueuePtrW'(1);
  assign n_push     = {1'b0, push_i.v0} + {1'b0, push_i.v1};

  always_comb begin
    wr_d  = wr_q + sipr_pkg::QueuePtrW'(n_push);
    rd_d  = rd_q + sipr_pkg::QueuePtrW'(pop);
    cnt_d = cnt_q + sipr_pkg::QueueCntW'(n_push) - sipr_pkg::QueueCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.v0) begin
      mem_q[wr_q] <= push_i.d0;
    end
    if (push_i.v1) begin
      mem_q[wr_nxt] <= push_i.d1;
    end
  end

endmodule

// ===== design/soft_iq_phase_rotation_core.sv =====
// Top level of the soft I/Q phase ambiguity correction block.
// The slave stream carries one soft pair per item: tdata holds soft_i in
// bits 7:0 and soft_q in bits 15:8, and tlast marks the final pair of a buffer.
// The master stream carries corrected pairs in the same layout, with tlast set
// on the final corrected pair. The APB register phase_select at address 0
// chooses one of sixteen ambiguity cases; write it only while the block is idle.
// An accepted item is held in an input register until the queue has room,
// passes through the rotation and delay correction logic, and is written into
// a four-entry result queue, from which its results are offered in order.
// The block takes one item per cycle as long as the queue has room for two
// results, which the last pair of a buffer in delay modes may need.
// In delay modes a pair that is not last gives its result one item later.
// Reset empties the queue, drops any held I byte and sets phase_select to 0.
// When the receiver stalls, results collect in the queue and tready falls once
// fewer than two entries are free; nothing is lost.
module soft_iq_phase_rotation_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // soft_i [7:0], soft_q [15:8]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // out_i [7:0], out_q [15:8]
  output logic        m_tlast
);

  logic [3:0]                 phase_sel_q;
  logic                       cfg_hit;
  logic                       in_vld_q;
  sipr_pkg::pair_t            in_q;
  logic                       room2;
  logic                       adv;
  logic [sipr_pkg::ByteW-1:0] rot_i, rot_q;
  sipr_pkg::push_t            push;
  sipr_pkg::pair_t            out_pair;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[2] == 1'(sipr_pkg::CfgPhaseSel)) && (paddr[1:0] == 2'b00);
  assign prdata  = cfg_hit ? {28'd0, phase_sel_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_sel_q <= '0;
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      phase_sel_q <= pwdata[3:0];
    end
  end

  assign adv      = in_vld_q && room2;
  assign s_tready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_tready) begin
      in_vld_q <= s_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tready && s_tvalid) begin
      in_q <= '{last: s_tlast, q: s_tdata[15:8], i: s_tdata[7:0]};
    end
  end

  sipr_rotate u_rotate (
    .sel_i    (phase_sel_q[2:0]),
    .soft_i_i (in_q.i),
    .soft_q_i (in_q.q),
    .rot_i_o  (rot_i),
    .rot_q_o  (rot_q)
  );

  sipr_delay_fix u_delay_fix (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (adv),
    .delay_mode_i (phase_sel_q[3]),
    .rot_i_i      (rot_i),
    .rot_q_i      (rot_q),
    .last_i       (in_q.last),
    .push_o       (push)
  );

  sipr_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .room2_o    (room2),
    .m_tvalid_o (m_tvalid),
    .m_tready_i (m_tready),
    .m_pair_o   (out_pair)
  );

  assign m_tdata = {out_pair.q, out_pair.i};
  assign m_tlast = out_pair.last;

endmodule
